// File: rtl/ips_pkg.sv
package ips_pkg;

   localparam int SLOTS_DEFAULT = 32;
   localparam int SLOTS_LIMIT   = 64;

   localparam int CMD_W    = 2;
   localparam int SLOT_ID_W = 6;
   localparam int TS_W     = 64;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 32;
   localparam int TIME_W   = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_BEGIN = 2'd0,
      CMD_END   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_BAD_SLOT     = 3'd1,
      ST_NO_TICK      = 3'd2,
      ST_ALREADY_OPEN = 3'd3,
      ST_NOT_OPEN     = 3'd4
   } status_type;

   // One slot's stored record. The open flag lives in flip-flops of its own.
   typedef struct packed {
      logic [TIME_W-1:0]  start_time;
      logic [TIME_W-1:0]  total_time;
      logic [TIME_W-1:0]  min_time;
      logic [TIME_W-1:0]  max_time;
      logic [COUNT_W-1:0] sample_count;
   } slot_entry_type;

endpackage

// File: rtl/interval_profiler_slots_core.sv
// Channel   Ports                                    Direction  Moves
// req       req_valid/req_stall, cmd/slot/timestamp  in         one command per beat
// rsp       rsp_valid/rsp_stall, status and stats    out        one result per command
// csr       csr_wr_en/csr_wr_data                    in         tick_enabled register
//
// A command can be taken every cycle while req_stall is low. The slot record is read
// into the input register at the beat, and the result is computed from it and held in the result register.
// A command right behind a write to the same slot takes the record through a bypass.
// Synchronous reset clears all slots at once through per-slot valid bits.
// rsp_stall holds the result register; req_stall rises only while both the
// compute stage and the result register are full.
module interval_profiler_slots_core #(
   parameter int SLOTS = ips_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic                           csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ips_pkg::CMD_W-1:0]      req_cmd,
   input  logic [ips_pkg::SLOT_ID_W-1:0]  req_slot_id,
   input  logic [ips_pkg::TS_W-1:0]       req_timestamp,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ips_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ips_pkg::COUNT_W-1:0]    rsp_meas_count,
   output logic [ips_pkg::TIME_W-1:0]     rsp_meas_total,
   output logic [ips_pkg::TIME_W-1:0]     rsp_meas_min,
   output logic [ips_pkg::TIME_W-1:0]     rsp_meas_max
);
   import ips_pkg::*;

   localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic tick_enabled_ff;

   slot_entry_type mem [SLOTS];
   slot_entry_type mem_rd_ff;
   logic [SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [SLOTS-1:0] slot_open_ff, slot_open_in;

   logic             s1_valid_ff;
   cmd_type          s1_cmd_ff;
   logic             s1_bad_ff;
   logic [SlotW-1:0] s1_addr_ff;
   logic [TS_W-1:0]  s1_ts_ff;
   logic             s1_fwd_ff;
   slot_entry_type   s1_fwd_entry_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic [TIME_W-1:0]    rsp_total_ff;
   logic [TIME_W-1:0]    rsp_min_ff;
   logic [TIME_W-1:0]    rsp_max_ff;

   logic             out_free, advance, accept;
   logic             req_bad;
   logic [SlotW-1:0] req_addr;
   logic             forward;

   slot_entry_type   cur_entry, new_entry;
   logic             cur_open, new_open;
   logic             write_back;
   status_type       status;
   logic [TIME_W-1:0] delta;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign req_bad  = {1'b0, req_slot_id} >= (SLOT_ID_W+1)'(SLOTS);
   assign req_addr = SlotW'(req_slot_id);
   assign forward  = advance && write_back && (s1_addr_ff == req_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_enabled_ff <= 1'b0;
      end else if (csr_wr_en) begin
         tick_enabled_ff <= csr_wr_data;
      end
   end

   // Slot record memory: one write port from the compute stage, one read port.
   always_ff @(posedge clock) begin
      if (advance && write_back) begin
         mem[s1_addr_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff <= mem[req_addr];
      end
   end

   // Valid and open flags are written back in the same cycle as the record, so
   // the compute stage can read them directly at its own address.
   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_open_in  = slot_open_ff;
      if (advance && write_back) begin
         slot_valid_in[s1_addr_ff] = 1'b1;
         slot_open_in[s1_addr_ff]  = new_open;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         slot_open_ff  <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         slot_open_ff  <= slot_open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff       <= cmd_type'(req_cmd);
         s1_bad_ff       <= req_bad;
         s1_addr_ff      <= req_addr;
         s1_ts_ff        <= req_timestamp;
         s1_fwd_ff       <= forward;
         s1_fwd_entry_ff <= new_entry;
      end
   end

   always_comb begin
      cur_entry = '0;
      cur_open  = 1'b0;
      if (!s1_bad_ff && slot_valid_ff[s1_addr_ff]) begin
         cur_entry = s1_fwd_ff ? s1_fwd_entry_ff : mem_rd_ff;
      end
      if (!s1_bad_ff) begin
         cur_open = slot_open_ff[s1_addr_ff];
      end

      delta      = s1_ts_ff - cur_entry.start_time;
      new_entry  = cur_entry;
      new_open   = cur_open;
      write_back = 1'b0;
      status     = ST_OK;

      if (s1_bad_ff) begin
         status = ST_BAD_SLOT;
      end else begin
         unique case (s1_cmd_ff)
            CMD_BEGIN: begin
               if (!tick_enabled_ff) begin
                  status = ST_NO_TICK;
               end else if (cur_open) begin
                  status = ST_ALREADY_OPEN;
               end else begin
                  new_entry.start_time = s1_ts_ff;
                  new_open             = 1'b1;
                  write_back           = 1'b1;
               end
            end
            CMD_END: begin
               if (!tick_enabled_ff) begin
                  status = ST_NO_TICK;
               end else if (!cur_open) begin
                  status = ST_NOT_OPEN;
               end else begin
                  // The first interval after a clear or a count wrap sets the minimum.
                  if (cur_entry.sample_count == '0 || delta < cur_entry.min_time) begin
                     new_entry.min_time = delta;
                  end
                  if (delta > cur_entry.max_time) begin
                     new_entry.max_time = delta;
                  end
                  new_entry.total_time   = cur_entry.total_time + delta;
                  new_entry.sample_count = cur_entry.sample_count + COUNT_W'(1);
                  new_open               = 1'b0;
                  write_back             = 1'b1;
               end
            end
            CMD_READ: begin
            end
            CMD_CLEAR: begin
               new_entry.total_time   = '0;
               new_entry.min_time     = '0;
               new_entry.max_time     = '0;
               new_entry.sample_count = '0;
               new_open               = 1'b0;
               write_back             = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= status;
         rsp_count_ff  <= s1_bad_ff ? '0 : new_entry.sample_count;
         rsp_total_ff  <= s1_bad_ff ? '0 : new_entry.total_time;
         rsp_min_ff    <= s1_bad_ff ? '0 : new_entry.min_time;
         rsp_max_ff    <= s1_bad_ff ? '0 : new_entry.max_time;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_meas_count = rsp_count_ff;
   assign rsp_meas_total = rsp_total_ff;
   assign rsp_meas_min   = rsp_min_ff;
   assign rsp_meas_max   = rsp_max_ff;

endmodule

// File: rtl/ips_checker.sv
module ips_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ips_pkg::STATUS_W-1:0]  rsp_status,
   input logic [ips_pkg::COUNT_W-1:0]   rsp_meas_count,
   input logic [ips_pkg::TIME_W-1:0]    rsp_meas_total,
   input logic [ips_pkg::TIME_W-1:0]    rsp_meas_min,
   input logic [ips_pkg::TIME_W-1:0]    rsp_meas_max
);
   import ips_pkg::*;

   // A stalled result beat keeps its status, count and total.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_meas_count) && $stable(rsp_meas_total))
      else $error("stalled result changed");

   // The command side is held back only while a result is waiting.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("command stalled with empty result register");

   // A bad slot reports no statistics.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BAD_SLOT |-> rsp_meas_count == '0
         && rsp_meas_total == '0 && rsp_meas_min == '0 && rsp_meas_max == '0)
      else $error("bad slot result carries statistics");

   // Once a slot has a measurement, its minimum cannot exceed its maximum.
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_meas_count != '0 |-> rsp_meas_min <= rsp_meas_max)
      else $error("minimum above maximum");

endmodule

bind interval_profiler_slots_core ips_checker u_ips_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_meas_count (rsp_meas_count),
   .rsp_meas_total (rsp_meas_total),
   .rsp_meas_min   (rsp_meas_min),
   .rsp_meas_max   (rsp_meas_max)
);
